>>> src/block_quant_dequantizer_core_defines.svh
// assertion macros for the block quantized tensor dequantizer
`ifndef BLOCK_QUANT_DEQUANTIZER_CORE_DEFINES_SVH
`define BLOCK_QUANT_DEQUANTIZER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define BQD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define BQD_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define BQD_ASSERT(label, prop, msg)
`define BQD_ASSERT_RST(label, prop, msg)
`endif
`endif

>>> src/bqd_pkg.sv
// shared types, constants and functions of the block dequantizer
`timescale 1ns / 1ps
`default_nettype none
package bqd_pkg;

   typedef enum logic [2:0] {
      MODE_F32  = 3'd0,
      MODE_F16  = 3'd1,
      MODE_Q4_0 = 3'd2,
      MODE_Q4_1 = 3'd3,
      MODE_Q8_0 = 3'd4,
      MODE_Q4_K = 3'd5,
      MODE_Q5_K = 3'd6
   } mode_type;

   typedef enum logic [1:0] {
      KIND_RAW    = 2'd0,
      KIND_PROD   = 2'd1,
      KIND_AFFINE = 2'd2,
      KIND_KQ     = 2'd3
   } kind_type;

   localparam logic [31:0] NAN_BITS   = 32'h7FC0_0000;
   localparam logic [2:0]  MODE_RESET = 3'd2;
   localparam logic [7:0]  KQ_DATA_POS  = 8'd16;
   localparam logic [7:0]  K5_HBIT_POS  = 8'd16;
   localparam logic [7:0]  K5_DATA_POS  = 8'd48;
   localparam logic [7:0]  K_SCALE_POS  = 8'd4;

   // one queued request: everything the back end needs for its results
   typedef struct packed {
      logic              two;
      kind_type          kind;
      logic signed [8:0] qa;
      logic signed [8:0] qb;
      logic [5:0]        sc;
      logic [5:0]        mn;
      logic [15:0]       dh;
      logic [15:0]       mh;
      logic [31:0]       raw;
      logic              tend;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   function automatic logic [7:0] block_len(input logic [2:0] mode);
      logic [7:0] len;
      unique case (mode)
         MODE_F32:  len = 8'd4;
         MODE_F16:  len = 8'd2;
         MODE_Q4_0: len = 8'd18;
         MODE_Q4_1: len = 8'd20;
         MODE_Q8_0: len = 8'd34;
         MODE_Q4_K: len = 8'd144;
         MODE_Q5_K: len = 8'd176;
         default:   len = 8'd0;
      endcase
      return len;
   endfunction

   // exact widening of a half to single, nan payload kept
   function automatic logic [31:0] half_to_single(input logic [15:0] h);
      logic [4:0]  e;
      logic [9:0]  m;
      logic [10:0] mm;
      logic [7:0]  e2;
      logic [31:0] r;
      e  = h[14:10];
      m  = h[9:0];
      mm = {1'b0, m};
      e2 = 8'd113;
      r  = {h[15], 31'd0};
      if (e == 5'd0) begin
         if (m != 10'd0) begin
            for (int i = 0; i < 10; i++) begin
               if (!mm[10]) begin
                  mm = mm << 1;
                  e2 = e2 - 8'd1;
               end
            end
            r = {h[15], e2, mm[9:0], 13'd0};
         end
      end else if (e == 5'd31) begin
         r = {h[15], 8'hFF, m, 13'd0};
      end else begin
         r = {h[15], {3'd0, e} + 8'd112, m, 13'd0};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> src/bqd_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface bqd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;
   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface bqd_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] value_bits;
   logic        last_of_run;
   logic        tensor_end;
   modport source (output valid, output value_bits, output last_of_run,
                   output tensor_end, input ready);
   modport sink (input valid, input value_bits, input last_of_run,
                 input tensor_end, output ready);
endinterface
`default_nettype wire

>>> src/bqd_front.sv
// front end: byte position tracking, block headers and request classification
`timescale 1ns / 1ps
`default_nettype none
module bqd_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_we,
   input  wire logic [2:0]        csr_wdata,
   bqd_req_if.sink                req,
   input  wire bqd_pkg::qstat_type q_stat,
   output logic                   push,
   output bqd_pkg::job_type       job
);

   logic [2:0]  mode_ff, mode_in;
   logic [7:0]  pos_ff, pos_in;
   logic [15:0] scale_ff, scale_in;
   logic [15:0] min_ff, min_in;
   logic [23:0] part_ff, part_in;
   logic [7:0]  ps_ff [12];
   logic [7:0]  hb_ff [32];

   logic        accept;
   logic [7:0]  len, pos, pos_nx, rel, jk;
   logic [3:0]  lo, hi;
   logic [7:0]  b;
   logic [5:0]  sc_all [8];
   logic [5:0]  mn_all [8];
   logic [7:0]  hb;
   logic        ps_we, hb_we;
   logic [3:0]  ps_idx;
   logic [4:0]  hb_idx;

   assign req.ready = !q_stat.full;
   assign accept    = req.valid && req.ready;
   assign b         = req.data_byte;
   assign lo        = b[3:0];
   assign hi        = b[7:4];
   assign len       = bqd_pkg::block_len(mode_ff);
   assign pos       = (pos_ff >= len) ? 8'd0 : pos_ff;
   assign pos_nx    = (pos + 8'd1 >= len) ? 8'd0 : pos + 8'd1;

   // per sub-block 6-bit scale and min, each from fixed packed bytes
   always_comb begin
      for (int s = 0; s < 8; s++) begin
         sc_all[s] = ps_ff[s][5:0];
         if (s < 4) begin
            mn_all[s] = {ps_ff[s + 8][3:0], ps_ff[s][7:6]};
         end else begin
            mn_all[s] = {ps_ff[s + 4][7:4], ps_ff[s][7:6]};
         end
      end
   end

   assign rel    = pos - bqd_pkg::K_SCALE_POS;
   assign ps_idx = rel[3:0];
   assign jk     = (mode_ff == bqd_pkg::MODE_Q5_K) ? pos - bqd_pkg::K5_DATA_POS
                                                   : pos - bqd_pkg::KQ_DATA_POS;
   assign hb_idx = (pos[4:0] - bqd_pkg::K5_HBIT_POS[4:0]);
   assign hb     = hb_ff[jk[6:2]];

   always_comb begin
      mode_in  = mode_ff;
      pos_in   = pos_ff;
      scale_in = scale_ff;
      min_in   = min_ff;
      part_in  = part_ff;
      ps_we    = 1'b0;
      hb_we    = 1'b0;
      push     = 1'b0;
      job      = '0;
      job.dh   = scale_ff;
      job.mh   = min_ff;
      job.tend = req.last_byte;
      job.sc   = sc_all[jk[6:4]];
      job.mn   = mn_all[jk[6:4]];
      if (csr_we) begin
         mode_in = csr_wdata;
         pos_in  = 8'd0;
         part_in = 24'd0;
      end else if (accept) begin
         pos_in = pos_nx;
         unique case (mode_ff)
            bqd_pkg::MODE_F32: begin
               case (pos)
                  8'd0:    part_in = {16'd0, b};
                  8'd1:    part_in[15:8] = b;
                  8'd2:    part_in[23:16] = b;
                  default: begin
                     push     = 1'b1;
                     job.kind = bqd_pkg::KIND_RAW;
                     job.raw  = {b, part_ff};
                  end
               endcase
            end
            bqd_pkg::MODE_F16: begin
               if (pos == 8'd0) begin
                  part_in = {16'd0, b};
               end else begin
                  push     = 1'b1;
                  job.kind = bqd_pkg::KIND_RAW;
                  job.raw  = bqd_pkg::half_to_single({b, part_ff[7:0]});
               end
            end
            bqd_pkg::MODE_Q4_0, bqd_pkg::MODE_Q8_0: begin
               if (pos == 8'd0) begin
                  scale_in[7:0] = b;
               end else if (pos == 8'd1) begin
                  scale_in[15:8] = b;
               end else begin
                  push     = 1'b1;
                  job.kind = bqd_pkg::KIND_PROD;
                  if (mode_ff == bqd_pkg::MODE_Q4_0) begin
                     job.two = 1'b1;
                     job.qa  = $signed({5'd0, lo}) - 9'sd8;
                     job.qb  = $signed({5'd0, hi}) - 9'sd8;
                  end else begin
                     job.qa  = $signed({b[7], b});
                  end
               end
            end
            bqd_pkg::MODE_Q4_1: begin
               case (pos)
                  8'd0:    scale_in[7:0] = b;
                  8'd1:    scale_in[15:8] = b;
                  8'd2:    min_in[7:0] = b;
                  8'd3:    min_in[15:8] = b;
                  default: begin
                     push     = 1'b1;
                     job.two  = 1'b1;
                     job.kind = bqd_pkg::KIND_AFFINE;
                     job.qa   = $signed({5'd0, lo});
                     job.qb   = $signed({5'd0, hi});
                  end
               endcase
            end
            bqd_pkg::MODE_Q4_K, bqd_pkg::MODE_Q5_K: begin
               if (pos == 8'd0) begin
                  scale_in[7:0] = b;
               end else if (pos == 8'd1) begin
                  scale_in[15:8] = b;
               end else if (pos == 8'd2) begin
                  min_in[7:0] = b;
               end else if (pos == 8'd3) begin
                  min_in[15:8] = b;
               end else if (pos < bqd_pkg::KQ_DATA_POS) begin
                  ps_we = 1'b1;
               end else if (mode_ff == bqd_pkg::MODE_Q5_K && pos < bqd_pkg::K5_DATA_POS) begin
                  hb_we = 1'b1;
               end else begin
                  push     = 1'b1;
                  job.two  = 1'b1;
                  job.kind = bqd_pkg::KIND_KQ;
                  if (mode_ff == bqd_pkg::MODE_Q5_K) begin
                     job.qa = $signed({4'd0, hb[{jk[1:0], 1'b0}], lo});
                     job.qb = $signed({4'd0, hb[{jk[1:0], 1'b1}], hi});
                  end else begin
                     job.qa = $signed({5'd0, lo});
                     job.qb = $signed({5'd0, hi});
                  end
               end
            end
            default: begin
               pos_in = 8'd0;
            end
         endcase
         if (req.last_byte) begin
            pos_in  = 8'd0;
            part_in = 24'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= bqd_pkg::MODE_RESET;
         pos_ff   <= 8'd0;
         scale_ff <= 16'd0;
         min_ff   <= 16'd0;
         part_ff  <= 24'd0;
      end else begin
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         scale_ff <= scale_in;
         min_ff   <= min_in;
         part_ff  <= part_in;
      end
   end

   // packed sub-scale and high-bit stores, no reset
   always_ff @(posedge clock) begin
      if (ps_we) begin
         ps_ff[ps_idx] <= b;
      end
      if (hb_we) begin
         hb_ff[hb_idx] <= b;
      end
   end

endmodule
`default_nettype wire

>>> src/bqd_queue.sv
// two-entry request queue between front and back end
`timescale 1ns / 1ps
`default_nettype none
module bqd_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire bqd_pkg::job_type  wdata,
   input  wire logic              pop,
   output bqd_pkg::job_type       rdata,
   output bqd_pkg::qstat_type     q_stat
);

   bqd_pkg::job_type ent_ff [2];
   logic       wp_ff, wp_in;
   logic       rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;

   assign rdata        = ent_ff[rp_ff];
   assign q_stat.full  = (cnt_ff == 2'd2);
   assign q_stat.empty = (cnt_ff == 2'd0);

   always_comb begin
      wp_in  = wp_ff ^ push;
      rp_in  = rp_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wp_ff] <= wdata;
      end
   end

endmodule
`default_nettype wire

>>> src/bqd_back.sv
// back end: f32 arithmetic pipeline, one result per cycle unless the output is stalled
`timescale 1ns / 1ps
`default_nettype none
module bqd_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire bqd_pkg::job_type head,
   input  wire logic             head_valid,
   output logic                  pop,
   bqd_rsp_if.source             rsp
);

   typedef struct packed {
      logic        raw;
      logic [31:0] rbits;
      logic        last;
      logic        tend;
   } tag_type;

   typedef struct packed {
      tag_type     tag;
      logic [15:0] hx;
      logic [10:0] kx;
      logic        ksx;
      logic [15:0] hy;
      logic [5:0]  ky;
      logic        ksy;
   } s1_type;

   typedef struct packed {
      tag_type           tag;
      logic [21:0]       mx;
      logic signed [5:0] ex;
      logic              sx, ix, nx;
      logic [16:0]       my;
      logic signed [5:0] ey;
      logic              sy, iy, ny;
   } s2_type;

   typedef struct packed {
      tag_type           tag;
      logic [52:0]       sum;
      logic signed [5:0] e0;
      logic              rnan, rinf, isign, zsign;
   } s3_type;

   typedef struct packed {
      tag_type           tag;
      logic [51:0]       mag;
      logic              sign;
      logic signed [5:0] e0;
      logic              rnan, rinf, isign, zsign;
   } s4_type;

   typedef struct packed {
      tag_type           tag;
      logic [51:0]       mag;
      logic [5:0]        msb;
      logic              sign;
      logic signed [5:0] e0;
      logic              rnan, rinf, isign, zsign;
   } s5_type;

   logic   adv, issue, last;
   logic   idx_ff, idx_in;
   logic   v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   s4_type s4_ff, s4_in;
   s5_type s5_ff, s5_in;
   logic [31:0] val_ff, val_in;
   logic        last_ff, tend_ff;

   logic signed [8:0] q;
   logic [10:0]       mant_x, mant_y;
   logic              hix, hiy, hnx, hny;
   logic [4:0]        dx, dy;
   logic [5:0]        dxw, dyw;
   logic [51:0]       xs, ys;
   logic [52:0]       xt, yt;
   logic [5:0]        sh;
   logic [51:0]       norm;
   logic [24:0]       m25;
   logic              rup;
   logic [8:0]        ex9;

   assign adv    = !v6_ff || rsp.ready;
   assign issue  = adv && head_valid;
   assign last   = !head.two || idx_ff;
   assign pop    = issue && last;
   assign idx_in = issue ? !last : idx_ff;

   // stage 1: pick the nibble and form the integer factors
   always_comb begin
      q               = idx_ff ? head.qb : head.qa;
      s1_in           = '0;
      s1_in.tag.rbits = head.raw;
      s1_in.tag.last  = last;
      s1_in.tag.tend  = head.tend;
      s1_in.hx        = head.dh;
      s1_in.hy        = head.mh;
      unique case (head.kind)
         bqd_pkg::KIND_RAW: begin
            s1_in.tag.raw = 1'b1;
         end
         bqd_pkg::KIND_PROD: begin
            s1_in.kx  = q[8] ? 11'(-q) : 11'(q);
            s1_in.ksx = q[8];
            s1_in.hy  = 16'd0;
            s1_in.ksy = 1'b1;
         end
         bqd_pkg::KIND_AFFINE: begin
            s1_in.kx = 11'(q);
            s1_in.ky = 6'd1;
         end
         default: begin
            s1_in.kx  = 11'(q[4:0] * head.sc);
            s1_in.ky  = head.mn;
            s1_in.ksy = 1'b1;
         end
      endcase
   end

   // stage 2: half decode and the two exact products
   always_comb begin
      mant_x = (s1_ff.hx[14:10] == 5'd0) ? {1'b0, s1_ff.hx[9:0]} : {1'b1, s1_ff.hx[9:0]};
      mant_y = (s1_ff.hy[14:10] == 5'd0) ? {1'b0, s1_ff.hy[9:0]} : {1'b1, s1_ff.hy[9:0]};
      hix    = (s1_ff.hx[14:10] == 5'd31) && (s1_ff.hx[9:0] == 10'd0);
      hnx    = (s1_ff.hx[14:10] == 5'd31) && (s1_ff.hx[9:0] != 10'd0);
      hiy    = (s1_ff.hy[14:10] == 5'd31) && (s1_ff.hy[9:0] == 10'd0);
      hny    = (s1_ff.hy[14:10] == 5'd31) && (s1_ff.hy[9:0] != 10'd0);
      s2_in.tag = s1_ff.tag;
      s2_in.mx  = 22'(mant_x * s1_ff.kx);
      s2_in.my  = 17'(mant_y * s1_ff.ky);
      s2_in.ex  = (s1_ff.hx[14:10] == 5'd0) ? -6'sd24
                                            : $signed({1'b0, s1_ff.hx[14:10]}) - 6'sd25;
      s2_in.ey  = (s1_ff.hy[14:10] == 5'd0) ? -6'sd24
                                            : $signed({1'b0, s1_ff.hy[14:10]}) - 6'sd25;
      s2_in.sx  = s1_ff.hx[15] ^ s1_ff.ksx;
      s2_in.sy  = s1_ff.hy[15] ^ s1_ff.ksy;
      s2_in.ix  = hix && (s1_ff.kx != 11'd0);
      s2_in.nx  = hnx || (hix && (s1_ff.kx == 11'd0));
      s2_in.iy  = hiy && (s1_ff.ky != 6'd0);
      s2_in.ny  = hny || (hiy && (s1_ff.ky == 6'd0));
   end

   // stage 3: align to the smaller exponent and add exactly
   always_comb begin
      s3_in.tag = s2_ff.tag;
      s3_in.e0  = (s2_ff.ex < s2_ff.ey) ? s2_ff.ex : s2_ff.ey;
      dxw       = 6'(s2_ff.ex - s3_in.e0);
      dyw       = 6'(s2_ff.ey - s3_in.e0);
      dx        = dxw[4:0];
      dy        = dyw[4:0];
      xs        = {30'd0, s2_ff.mx} << dx;
      ys        = {35'd0, s2_ff.my} << dy;
      xt        = s2_ff.sx ? -{1'b0, xs} : {1'b0, xs};
      yt        = s2_ff.sy ? -{1'b0, ys} : {1'b0, ys};
      s3_in.sum = xt + yt;
      s3_in.rnan  = s2_ff.nx || s2_ff.ny || (s2_ff.ix && s2_ff.iy && (s2_ff.sx != s2_ff.sy));
      s3_in.rinf  = s2_ff.ix || s2_ff.iy;
      s3_in.isign = s2_ff.ix ? s2_ff.sx : s2_ff.sy;
      // exact zero: minus only when both terms are minus zero
      s3_in.zsign = (s2_ff.mx == 22'd0) && (s2_ff.my == 17'd0) && s2_ff.sx && s2_ff.sy;
   end

   // stage 4: sign and magnitude
   always_comb begin
      s4_in.tag   = s3_ff.tag;
      s4_in.sign  = s3_ff.sum[52];
      s4_in.mag   = s3_ff.sum[52] ? (~s3_ff.sum[51:0] + 52'd1) : s3_ff.sum[51:0];
      s4_in.e0    = s3_ff.e0;
      s4_in.rnan  = s3_ff.rnan;
      s4_in.rinf  = s3_ff.rinf;
      s4_in.isign = s3_ff.isign;
      s4_in.zsign = s3_ff.zsign;
   end

   // stage 5: leading one search
   always_comb begin
      s5_in.tag   = s4_ff.tag;
      s5_in.mag   = s4_ff.mag;
      s5_in.sign  = s4_ff.sign;
      s5_in.e0    = s4_ff.e0;
      s5_in.rnan  = s4_ff.rnan;
      s5_in.rinf  = s4_ff.rinf;
      s5_in.isign = s4_ff.isign;
      s5_in.zsign = s4_ff.zsign;
      s5_in.msb   = 6'd0;
      for (int i = 0; i < 52; i++) begin
         if (s4_ff.mag[i]) begin
            s5_in.msb = 6'(i);
         end
      end
   end

   // stage 6: normalize, round to nearest even, pack
   always_comb begin
      sh   = 6'd51 - s5_ff.msb;
      norm = s5_ff.mag << sh;
      rup  = norm[27] && ((|norm[26:0]) || norm[28]);
      m25  = {1'b0, norm[51:28]} + {24'd0, rup};
      ex9  = {3'd0, s5_ff.msb} + {{3{s5_ff.e0[5]}}, s5_ff.e0} + 9'd127 + {8'd0, m25[24]};
      if (s5_ff.tag.raw) begin
         val_in = s5_ff.tag.rbits;
      end else if (s5_ff.rnan) begin
         val_in = bqd_pkg::NAN_BITS;
      end else if (s5_ff.rinf) begin
         val_in = {s5_ff.isign, 8'hFF, 23'd0};
      end else if (s5_ff.mag == 52'd0) begin
         val_in = {s5_ff.zsign, 31'd0};
      end else begin
         val_in = {s5_ff.sign, ex9[7:0], m25[24] ? 23'd0 : m25[22:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 1'b0;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
         v5_ff  <= 1'b0;
         v6_ff  <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         if (adv) begin
            v1_ff <= issue;
            v2_ff <= v1_ff;
            v3_ff <= v2_ff;
            v4_ff <= v3_ff;
            v5_ff <= v4_ff;
            v6_ff <= v5_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff   <= s1_in;
         s2_ff   <= s2_in;
         s3_ff   <= s3_in;
         s4_ff   <= s4_in;
         s5_ff   <= s5_in;
         val_ff  <= val_in;
         last_ff <= s5_ff.tag.last;
         tend_ff <= s5_ff.tag.tend;
      end
   end

   assign rsp.valid       = v6_ff;
   assign rsp.value_bits  = val_ff;
   assign rsp.last_of_run = last_ff;
   assign rsp.tensor_end  = tend_ff;

endmodule
`default_nettype wire

>>> src/block_quant_dequantizer_core.sv
// top level of the streaming block quantized tensor dequantizer
// usage:
//   req carries one tensor byte per request (data_byte, last_byte flags the
//   final byte of a tensor). rsp carries one f32 weight per transfer, with
//   last_of_run on the final result of a byte and tensor_end on results
//   caused by the flagged byte.
//   csr_we / csr_wdata write format_mode (0 f32, 1 f16, 2 q4_0, 3 q4_1,
//   4 q8_0, 5 q4_k, 6 q5_k); a write restarts the block position. write it
//   only while no request is in flight.
// datapath: a byte with results is written into the queue when accepted, then
//   passes the six-stage f32 pipeline incl. output reg.
// throughput: the arithmetic pipeline retires one result per cycle unless rsp stalls;
//   nibble formats (q4_0, q4_1, q4_k, q5_k) give two results per data byte;
//   header bytes are consumed in the front without queue use.
// reset: synchronous, active high; clears position, scale, min, mode (q4_0)
//   and empties queue and pipeline. no clearing pass.
// stall: while rsp.valid is high and rsp.ready is low the pipeline holds;
//   the two-entry queue then fills and req.ready drops.
`timescale 1ns / 1ps
`default_nettype none
`include "block_quant_dequantizer_core_defines.svh"
module block_quant_dequantizer_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_we,
   input  wire logic [2:0] csr_wdata,
   bqd_req_if.sink         req,
   bqd_rsp_if.source       rsp
);

   // front to queue
   logic               push;
   bqd_pkg::job_type   job;
   // queue to back
   bqd_pkg::job_type   head;
   bqd_pkg::qstat_type q_stat;
   logic               pop;

   // front: position tracking, header capture, request classification
   bqd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req       (req),
      .q_stat    (q_stat),
      .push      (push),
      .job       (job)
   );

   // decoupling queue so each side can stall on its own
   bqd_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .wdata  (job),
      .pop    (pop),
      .rdata  (head),
      .q_stat (q_stat)
   );

   // back: f32 products, exact add and single rounding
   bqd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (!q_stat.empty),
      .pop        (pop),
      .rsp        (rsp)
   );

   `BQD_ASSERT(a_push_room, push |-> !q_stat.full, "request pushed into full queue")
   `BQD_ASSERT(a_pop_data, pop |-> !q_stat.empty, "request popped from empty queue")
   `BQD_ASSERT(a_stat_sane, !(q_stat.full && q_stat.empty), "queue full and empty")
   `BQD_ASSERT_RST(a_reset_empty, $past(reset) |-> q_stat.empty, "queue not empty after reset")

endmodule
`default_nettype wire
